### src/cba_pkg.sv
// Shared constants for the contiguous block allocator and its checker.
package cba_pkg;

  // Default block count and fixed field widths
  localparam int unsigned NUM_BLOCKS_DEF = 64;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned STRAT_W        = 2;
  localparam int unsigned INDEX_W        = 6;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned MAP_W          = 64;
  // Width of a range end: start index plus count
  localparam int unsigned SPAN_W         = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEFRAG = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

  // Fit strategy codes; the spare code behaves as worst fit
  localparam logic [STRAT_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [STRAT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] FIT_WORST = 2'd2;
  localparam logic [STRAT_W-1:0] FIT_SPARE = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd2;

endpackage

### src/contiguous_block_allocator.sv
// Contiguous block allocator: allocation bits in a 1-bit wide memory, scanned per command.
//
// Usage: drive cmd_i, block_count_i, fit_strategy_i and start_index_i and raise start.
// The command is taken at a rising edge where start is high and busy is low; busy then
// stays high until the result has been shown. The result (status_o, alloc_start_o,
// used_map_o) is valid for exactly one cycle while done_o is high; the receiver must
// take it then, it cannot stall the block.
// Timing: every command reads the allocation memory once, one block per cycle, with a
// run-closing step past the last block. Commands that change the map (a fitting
// allocate, a valid free, a defragment) then write the memory back, one block per
// cycle. The result follows in the next cycle, and busy drops the cycle after that.
// The time a command takes is bounded by the single memory port that sees one block
// per cycle.
// Reset: asynchronous, active low. All blocks read as free after reset through a
// per-block valid flag; no clearing pass is needed, so the block is ready at once.
module contiguous_block_allocator #(
  parameter int unsigned NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [cba_pkg::CMD_W-1:0]    cmd_i,
  input  logic [cba_pkg::COUNT_W-1:0]  block_count_i,
  input  logic [cba_pkg::STRAT_W-1:0]  fit_strategy_i,
  input  logic [cba_pkg::INDEX_W-1:0]  start_index_i,
  output logic                         done_o,
  output logic [cba_pkg::STATUS_W-1:0] status_o,
  output logic [cba_pkg::INDEX_W-1:0]  alloc_start_o,
  output logic [cba_pkg::MAP_W-1:0]    used_map_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SW = cba_pkg::SPAN_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [cba_pkg::CMD_W-1:0]    cmd_q;
  logic [cba_pkg::COUNT_W-1:0]  count_q;
  logic [cba_pkg::STRAT_W-1:0]  strat_q;
  logic [cba_pkg::INDEX_W-1:0]  sidx_q;
  logic                         bad_q;
  logic [CW-1:0]                run_len_q, run_len_d;
  logic [AW-1:0]                run_start_q, run_start_d;
  logic [CW-1:0]                best_len_q, best_len_d;
  logic [AW-1:0]                best_start_q, best_start_d;
  logic                         found_q, found_d;
  logic [CW-1:0]                ones_q, ones_d;
  logic [NUM_BLOCKS-1:0]        map_q, map_d;
  logic [cba_pkg::STATUS_W-1:0] status_q, status_d;
  logic [cba_pkg::INDEX_W-1:0]  astart_q, astart_d;

  // Memory and its port
  logic                  mem_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;
  logic                  rdata_q, rvld_q;
  logic                  rd_en;
  logic [CW:0]           rd_nxt;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic                  wr_bit;
  logic                  rd_bit;

  logic                  accept;
  logic                  is_free;
  logic                  fits;
  logic                  take;
  logic                  last_read;
  logic [SW-1:0]         lo8, hi8, i8;
  logic                  in_rng;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign rd_bit = rdata_q & rvld_q;

  // Read address runs one block ahead of the block being scanned
  assign rd_nxt  = (CW + 1)'(cnt_q) + (CW + 1)'(1);
  assign rd_addr = (state_q == S_IDLE) ? '0 : rd_nxt[AW-1:0];
  assign rd_en   = accept || ((state_q == S_READ) && (rd_nxt < (CW + 1)'(NUM_BLOCKS)));

  // Synchronous read; unwritten blocks read as free
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      rvld_q  <= vld_q[rd_addr];
    end
    if (we) begin
      mem_q[wr_addr] <= wr_bit;
    end
  end

  // Mark written blocks valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Range of the write pass: chosen run for allocate, given range for free
  assign lo8    = (cmd_q == cba_pkg::CMD_ALLOC) ? SW'(best_start_q) : SW'(sidx_q);
  assign hi8    = lo8 + SW'(count_q);
  assign i8     = SW'(cnt_q);
  assign in_rng = (i8 >= lo8) && (i8 < hi8);

  // Write data per command
  always_comb begin
    wr_bit = map_q[0];
    unique case (cmd_q)
      cba_pkg::CMD_ALLOC:  wr_bit = map_q[0] | in_rng;
      cba_pkg::CMD_FREE:   wr_bit = map_q[0] & ~in_rng;
      cba_pkg::CMD_DEFRAG: wr_bit = (cnt_q < ones_q);
      cba_pkg::CMD_STATUS: wr_bit = map_q[0];
    endcase
  end

  assign we      = (state_q == S_WRITE);
  assign wr_addr = cnt_q[AW-1:0];

  // Run tracking for one scanned block; past the last block every run closes
  assign last_read = (cnt_q == CW'(NUM_BLOCKS));
  assign is_free   = !last_read && !rd_bit;
  assign fits      = (count_q != '0) && (cba_pkg::COUNT_W'(run_len_q) >= count_q);

  always_comb begin
    priority if (!found_q)                  take = 1'b1;
    else if (strat_q == cba_pkg::FIT_FIRST) take = 1'b0;
    else if (strat_q == cba_pkg::FIT_BEST)  take = (run_len_q < best_len_q);
    else                                    take = (run_len_q > best_len_q);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    run_len_d    = run_len_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    found_d      = found_q;
    ones_d       = ones_q;
    map_d        = map_q;
    status_d     = status_q;
    astart_d     = astart_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d   = S_READ;
          cnt_d     = '0;
          run_len_d = '0;
          found_d   = 1'b0;
          ones_d    = '0;
        end
      end
      S_READ: begin
        // Measure free runs and pick the fitting one
        if (is_free) begin
          if (run_len_q == '0) begin
            run_start_d = cnt_q[AW-1:0];
          end
          run_len_d = run_len_q + CW'(1);
        end else begin
          if (fits && take) begin
            found_d      = 1'b1;
            best_start_d = run_start_q;
            best_len_d   = run_len_q;
          end
          run_len_d = '0;
        end
        // Capture the old map and count allocated blocks
        if (!last_read) begin
          map_d  = {rd_bit, map_q[NUM_BLOCKS-1:1]};
          ones_d = ones_q + CW'(rd_bit);
          cnt_d  = cnt_q + CW'(1);
        end else begin
          cnt_d    = '0;
          astart_d = '0;
          status_d = cba_pkg::ST_OK;
          state_d  = S_DONE;
          unique case (cmd_q)
            cba_pkg::CMD_ALLOC: begin
              if (found_d) state_d = S_WRITE;
              else         status_d = cba_pkg::ST_NO_SPACE;
            end
            cba_pkg::CMD_FREE: begin
              if (bad_q) status_d = cba_pkg::ST_BAD_RANGE;
              else       state_d = S_WRITE;
            end
            cba_pkg::CMD_DEFRAG: state_d = S_WRITE;
            cba_pkg::CMD_STATUS: state_d = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        // Write back the new map and rebuild the output copy
        map_d = {wr_bit, map_q[NUM_BLOCKS-1:1]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NUM_BLOCKS - 1)) begin
          state_d  = S_DONE;
          status_d = cba_pkg::ST_OK;
          astart_d = (cmd_q == cba_pkg::CMD_ALLOC) ?
                     cba_pkg::INDEX_W'(best_start_q) : '0;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      status_q <= cba_pkg::ST_OK;
      astart_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      status_q <= status_d;
      astart_q <= astart_d;
    end
  end

  // Command and scan payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      count_q <= block_count_i;
      strat_q <= fit_strategy_i;
      sidx_q  <= start_index_i;
      bad_q   <= (SW'(start_index_i) + SW'(block_count_i)) > SW'(NUM_BLOCKS);
    end
    run_len_q    <= run_len_d;
    run_start_q  <= run_start_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    ones_q       <= ones_d;
    map_q        <= map_d;
  end

  // Result ports
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign alloc_start_o = astart_q;
  assign used_map_o    = cba_pkg::MAP_W'(map_q);

endmodule

### src/cba_checker.sv
// Port-level checker for the contiguous block allocator, bound to the top level.
module cba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [cba_pkg::STATUS_W-1:0] status_o,
  input logic [cba_pkg::INDEX_W-1:0]  alloc_start_o
);

  // An accepted transaction keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // A result is shown only while its transaction is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe without a transaction in flight");

  // One result per transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // Status holds a defined code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == cba_pkg::ST_OK || status_o == cba_pkg::ST_NO_SPACE ||
                status_o == cba_pkg::ST_BAD_RANGE))
    else $error("undefined status code");

  // Start block is zero on every failure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != cba_pkg::ST_OK) |-> (alloc_start_o == '0))
    else $error("nonzero start block on a failed transaction");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .alloc_start_o (alloc_start_o)
);
